// File: hdl/usbtmc_bulk_out_receiver_core_assert.svh
// Assertion macros for the USBTMC bulk-out receiver checker.
// Both macros expect a clock named clk and a reset named rst in scope.
`ifndef USBTMC_BULK_OUT_RECEIVER_CORE_ASSERT_SVH
`define USBTMC_BULK_OUT_RECEIVER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define USBRX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usbrx: assertion failed in the same cycle");

// Consequent checked in the cycle after the antecedent.
`define USBRX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usbrx: assertion failed one cycle later");

`endif

// File: hdl/usbrx_pkg.sv
// Shared constants, codes and types for the USBTMC bulk-out receiver.
// No dependencies; used by every module of the block.
package usbrx_pkg;

  // Sizes of the packet, the bulk-out header and the receive buffer in bytes.
  localparam int PACKET_BYTES = 64;
  localparam int HEADER_BYTES = 12;
  localparam int BUFFER_BYTES = 1024;
  localparam int FIRST_PAYLOAD_MAX = PACKET_BYTES - HEADER_BYTES;

  // Field widths.
  localparam int OP_W = 2;
  localparam int LEN_W = 7;
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 32;
  localparam int ERR_W = 3;
  localparam int CMD_W = 2;
  localparam int COUNT_W = 11;
  // Wide enough for header plus count plus packet length.
  localparam int SUM_W = 12;

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_PACKET = 2'd0;
  localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
  localparam logic [OP_W-1:0] OP_ABORT = 2'd2;

  // Header message ids.
  localparam logic [BYTE_W-1:0] ID_DEV_DEP_MSG_OUT = 8'd1;
  localparam logic [BYTE_W-1:0] ID_REQUEST_DEV_DEP_MSG_IN = 8'd2;
  localparam logic [BYTE_W-1:0] ID_VENDOR_SPECIFIC_OUT = 8'd126;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_ID = 3'd1;
  localparam logic [ERR_W-1:0] ERR_REPEATED_TAG = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_INVERSE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

  // Posted commands.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HOST_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HOST_READ = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [LEN_W-1:0]  packet_len;
    logic [BYTE_W-1:0] msg_id;
    logic [BYTE_W-1:0] tag;
    logic [BYTE_W-1:0] tag_inverse;
    logic [SIZE_W-1:0] transfer_size;
  } item_t;

  typedef struct packed {
    logic              receiving;
    logic              done_flag;
    logic [COUNT_W-1:0] byte_count;
    logic [ERR_W-1:0]  last_error;
    logic [BYTE_W-1:0] saved_id;
    logic [BYTE_W-1:0] saved_tag;
    logic [SIZE_W-1:0] saved_size;
    logic [BYTE_W-1:0] reply_tag;
    logic [SIZE_W-1:0] reply_size;
  } state_t;

endpackage

// File: hdl/usbrx_step.sv
// Next-state logic of the bulk-out receiver for one item.
// Purely combinational; depends on usbrx_pkg.
module usbrx_step (
  input  usbrx_pkg::item_t              item,
  input  usbrx_pkg::state_t             state,
  output usbrx_pkg::state_t             state_next,
  output logic [usbrx_pkg::CMD_W-1:0]   command
);
  import usbrx_pkg::*;

  logic [SUM_W-1:0]   fill;
  logic [COUNT_W-1:0] first_count;
  logic               finish;

  // Bytes the buffer would hold after this packet, header included.
  assign fill = SUM_W'(HEADER_BYTES) + SUM_W'(state.byte_count) + SUM_W'(item.packet_len);

  // Payload bytes in a first packet; a packet shorter than a header counts none.
  assign first_count = (item.packet_len >= LEN_W'(HEADER_BYTES)) ?
                       COUNT_W'(item.packet_len - LEN_W'(HEADER_BYTES)) : '0;

  always_comb begin
    state_next = state;
    finish = 1'b0;
    command = CMD_NONE;

    unique case (item.opcode)
      OP_PACKET: begin
        if (state.receiving) begin
          if (fill >= SUM_W'(BUFFER_BYTES)) begin
            state_next.last_error = ERR_OVERFLOW;
            state_next.receiving = 1'b0;
          end else begin
            state_next.byte_count = state.byte_count + COUNT_W'(item.packet_len);
            if (state.saved_size <= SIZE_W'(state_next.byte_count)) begin
              state_next.done_flag = 1'b1;
              state_next.last_error = ERR_NONE;
              state_next.receiving = 1'b0;
            end
            finish = state_next.done_flag;
          end
        end else begin
          state_next.done_flag = 1'b0;
          state_next.byte_count = first_count;
          if (item.tag == state.saved_tag) begin
            state_next.last_error = ERR_REPEATED_TAG;
          end else if ((item.tag & item.tag_inverse) != '0) begin
            state_next.last_error = ERR_BAD_INVERSE;
          end else begin
            state_next.last_error = ERR_NONE;
            state_next.saved_id = item.msg_id;
            state_next.saved_tag = item.tag;
            state_next.saved_size = item.transfer_size;
            if (first_count < COUNT_W'(FIRST_PAYLOAD_MAX) ||
                item.transfer_size <= SIZE_W'(FIRST_PAYLOAD_MAX)) begin
              state_next.done_flag = 1'b1;
            end else begin
              state_next.receiving = 1'b1;
            end
            finish = state_next.done_flag;
          end
        end
      end
      OP_CONSUME: begin
        state_next.done_flag = 1'b0;
        state_next.byte_count = '0;
      end
      OP_ABORT: begin
        state_next.receiving = 1'b0;
      end
      default: begin
      end
    endcase

    // Classification of a finished message.
    if (finish) begin
      if (state_next.saved_id == ID_DEV_DEP_MSG_OUT) begin
        command = CMD_HOST_WRITE;
      end else if (state_next.saved_id == ID_REQUEST_DEV_DEP_MSG_IN) begin
        command = CMD_HOST_READ;
        state_next.reply_tag = state_next.saved_tag;
        state_next.reply_size = state_next.saved_size;
      end else if (state_next.saved_id != ID_VENDOR_SPECIFIC_OUT) begin
        state_next.last_error = ERR_BAD_ID;
      end
    end
  end

endmodule

// File: hdl/usbtmc_bulk_out_receiver_core.sv
// Top level of the USBTMC bulk-out receiver: input register, state and result register.
// Depends on usbrx_pkg and usbrx_step.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-----------------------------------------------------
//   in      | in_valid / in_stall | opcode, packet_len, msg_id, tag, tag_inverse,
//           |                     | transfer_size
//   out     | out_valid/out_stall | error, done_res, command, payload_count, out_tag,
//           |                     | in_tag, request_size
//
// One transfer can be taken every cycle while in_stall is low; it is held in the input register
// and then loaded into the state register, where its result is offered.
// Reset clears the receiver state and both valid flags; outputs read zero until the first load.
// A stall on the result side holds the result and, once the input register is also full,
// raises in_stall in the same cycle; otherwise the input side keeps flowing.
module usbtmc_bulk_out_receiver_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [usbrx_pkg::OP_W-1:0]      opcode,
  input  logic [usbrx_pkg::LEN_W-1:0]     packet_len,
  input  logic [usbrx_pkg::BYTE_W-1:0]    msg_id,
  input  logic [usbrx_pkg::BYTE_W-1:0]    tag,
  input  logic [usbrx_pkg::BYTE_W-1:0]    tag_inverse,
  input  logic [usbrx_pkg::SIZE_W-1:0]    transfer_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [usbrx_pkg::ERR_W-1:0]     error,
  output logic                            done_res,
  output logic [usbrx_pkg::CMD_W-1:0]     command,
  output logic [usbrx_pkg::COUNT_W-1:0]   payload_count,
  output logic [usbrx_pkg::BYTE_W-1:0]    out_tag,
  output logic [usbrx_pkg::BYTE_W-1:0]    in_tag,
  output logic [usbrx_pkg::SIZE_W-1:0]    request_size
);
  import usbrx_pkg::*;

  // Input register: holds one accepted transfer until the result side has room.
  logic  item_valid;
  item_t item;

  // Receiver state. The state register doubles as the result register: it only
  // changes when a new result is loaded, so it holds still while a result is stalled.
  state_t           state;
  state_t           state_next;
  logic [CMD_W-1:0] cmd;
  logic [CMD_W-1:0] cmd_next;

  logic in_take;
  logic advance;

  // The held item moves on when the result register is empty or being emptied.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item.opcode        <= opcode;
      item.packet_len    <= packet_len;
      item.msg_id        <= msg_id;
      item.tag           <= tag;
      item.tag_inverse   <= tag_inverse;
      item.transfer_size <= transfer_size;
    end
  end

  usbrx_step u_step (
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .command    (cmd_next)
  );

  // All of the state has a defined reset value, so all of it is cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      cmd       <= CMD_NONE;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
        cmd   <= cmd_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign error         = state.last_error;
  assign done_res      = state.done_flag;
  assign command       = cmd;
  assign payload_count = state.byte_count;
  assign out_tag       = state.saved_tag;
  assign in_tag        = state.reply_tag;
  assign request_size  = state.reply_size;

endmodule

// File: hdl/usbrx_checker.sv
// Port-level checks of the bulk-out receiver, bound to its top level.
// Depends on usbrx_pkg and usbtmc_bulk_out_receiver_core_assert.svh.
`include "usbtmc_bulk_out_receiver_core_assert.svh"

module usbrx_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [usbrx_pkg::ERR_W-1:0]     error,
  input logic                            done_res,
  input logic [usbrx_pkg::CMD_W-1:0]     command,
  input logic [usbrx_pkg::COUNT_W-1:0]   payload_count,
  input logic [usbrx_pkg::BYTE_W-1:0]    out_tag,
  input logic [usbrx_pkg::BYTE_W-1:0]    in_tag,
  input logic [usbrx_pkg::SIZE_W-1:0]    request_size
);
  import usbrx_pkg::*;

  // All result fields side by side, so their stability is checked in one go.
  logic [ERR_W+CMD_W+COUNT_W+2*BYTE_W+SIZE_W:0] result_bits;

  assign result_bits = {error, done_res, command, payload_count, out_tag, in_tag,
                        request_size};

  // A stalled result stays offered.
  `USBRX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled result does not change.
  `USBRX_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_bits))

  // The input is only held off while a result is waiting on a stalled receiver.
  `USBRX_ASSERT_NOW(a_in_stall, in_stall, out_valid && out_stall)

  // A posted command only comes with a finished, error-free message.
  `USBRX_ASSERT_NOW(a_cmd_done, out_valid && command != CMD_NONE, done_res && error == ERR_NONE)

  // A finished message can only carry no error or an unknown id.
  `USBRX_ASSERT_NOW(a_done_err, out_valid && done_res, error == ERR_NONE || error == ERR_BAD_ID)

endmodule

bind usbtmc_bulk_out_receiver_core usbrx_port_checks u_usbrx_port_checks (.*);
